### hdl/ssf_pkg.sv
// ============================================================================
// ssf_pkg
// Shared types and constants for the shortest-seek-first request scheduler.
// ============================================================================
package ssf_pkg;

    // Default request buffer depth
    localparam int DEPTH_DEF = 64;

    // Field widths
    localparam int CYL_W  = 16;
    localparam int DIST_W = 22;

    // Stream widths
    localparam int S_DATA_W = 16;
    localparam int S_USER_W = 1;
    localparam int M_DATA_W = 40;
    localparam int M_USER_W = 2;

    // Running distance saturates here
    localparam logic [DIST_W-1:0] DIST_MAX = 22'h3FFFFF;

    // Operation codes carried on the input tuser
    typedef enum logic {
        OP_LOAD = 1'b0,
        OP_RUN  = 1'b1
    } t_op;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_WAIT,
        ST_EMIT
    } t_state;

    // Control from the sequencer to the nearest-entry tracker
    typedef struct packed {
        logic clear;  // start of a new scan
        logic vld;    // read word is valid this cycle
    } t_scan_ctl;

endpackage

### hdl/ssf_nearest.sv
// ============================================================================
// ssf_nearest
// Tracks the pending entry nearest the head over one scan of the buffer.
// ============================================================================
module ssf_nearest #(
    parameter int IW = 6
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  ssf_pkg::t_scan_ctl       i_ctl,
    input  logic [IW-1:0]            i_rd_idx,
    input  logic                     i_rd_pend,
    input  logic [ssf_pkg::CYL_W-1:0] i_rd_cyl,
    input  logic [ssf_pkg::CYL_W-1:0] i_head,
    output logic                     o_found,
    output logic [IW-1:0]            o_best_idx,
    output logic [ssf_pkg::CYL_W-1:0] o_best_cyl,
    output logic [ssf_pkg::CYL_W-1:0] o_best_d
);

    logic                      r_found;
    logic [IW-1:0]             r_best_idx;
    logic [ssf_pkg::CYL_W-1:0] r_best_cyl;
    logic [ssf_pkg::CYL_W-1:0] r_best_d;
    logic [ssf_pkg::CYL_W-1:0] w_d;
    logic                      w_take;

    // Distance of this word from the head; strict compare keeps lowest index
    assign w_d    = (i_head > i_rd_cyl) ? (i_head - i_rd_cyl) : (i_rd_cyl - i_head);
    assign w_take = i_ctl.vld && i_rd_pend && (!r_found || (w_d < r_best_d));

    // Found flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found <= 1'b0;
        end else if (i_ctl.clear) begin
            r_found <= 1'b0;
        end else if (w_take) begin
            r_found <= 1'b1;
        end
    end

    // Best candidate so far
    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_best_idx <= i_rd_idx;
            r_best_cyl <= i_rd_cyl;
            r_best_d   <= w_d;
        end
    end

    assign o_found    = r_found;
    assign o_best_idx = r_best_idx;
    assign o_best_cyl = r_best_cyl;
    assign o_best_d   = r_best_d;

endmodule

### hdl/shortest_seek_first_scheduler.sv
// ============================================================================
// shortest_seek_first_scheduler
// Buffers request cylinders and serves them nearest-first from a start head.
// ============================================================================
// A load word (tuser op = load) stores one cylinder in the buffer; loads beyond
// DEPTH are dropped and flagged. A run word gives the head start position; the
// block then emits one result word per stored request in nearest-first order,
// ties going to the earliest loaded request, with the running seek total. For
// each served request the block reads every buffered entry through the single
// read port of the buffer memory, passes a wait state for the registered read,
// then emits the result and retires the entry, the emit stalling while the
// output is held. A run with nothing buffered gives one result flagged empty.
// Input is taken only while no run is in progress; the last result of a run can
// still wait in the output register while the next word is accepted.
module shortest_seek_first_scheduler #(
    parameter int DEPTH = ssf_pkg::DEPTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_axis_tvalid,
    output logic                          o_s_axis_tready,
    input  logic [ssf_pkg::S_DATA_W-1:0]  i_s_axis_tdata,  // [15:0] cylinder
    input  logic [ssf_pkg::S_USER_W-1:0]  i_s_axis_tuser,  // [0] op
    output logic                          o_m_axis_tvalid,
    input  logic                          i_m_axis_tready,
    output logic [ssf_pkg::M_DATA_W-1:0]  o_m_axis_tdata,  // [15:0] served_cylinder,
                                                           // [37:16] total_distance
    output logic                          o_m_axis_tlast,
    output logic [ssf_pkg::M_USER_W-1:0]  o_m_axis_tuser   // [0] empty_res, [1] overflowed
);

    localparam int IW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW  = $clog2(DEPTH + 1);
    localparam int CYW = ssf_pkg::CYL_W;
    localparam int DW  = ssf_pkg::DIST_W;

    // Control
    ssf_pkg::t_state r_state, n_state;
    logic [CW-1:0]   r_count;
    logic            r_ovf;
    logic [IW-1:0]   r_idx;
    logic [CW-1:0]   r_served;
    logic            r_empty;
    logic            r_rd_vld;
    logic            r_m_valid;

    // Run context
    logic [CW-1:0]   r_n;
    logic            r_run_ovf;
    logic [CYW-1:0]  r_head;
    logic [DW-1:0]   r_sum;
    logic [IW-1:0]   r_rd_idx;

    // Buffer memory: {pending, cylinder}
    logic [CYW:0]    r_mem [0:DEPTH-1];
    logic [CYW:0]    r_rd_word;

    // Output register
    logic [CYW-1:0]  r_m_cyl;
    logic [DW-1:0]   r_m_dist;
    logic            r_m_last;
    logic            r_m_empty;
    logic            r_m_ovf;

    // Combinational
    ssf_pkg::t_op    w_op;
    logic            w_s_acc;
    logic            w_load;
    logic            w_run;
    logic            w_full;
    logic            w_fire;
    logic            w_issue_last;
    logic            w_served_last;
    logic            w_we;
    logic [IW-1:0]   w_wa;
    logic [CYW:0]    w_wd;
    logic [DW:0]     w_sum_ext;
    logic [DW-1:0]   w_sum_next;
    ssf_pkg::t_scan_ctl w_ctl;
    logic            w_found;
    logic [IW-1:0]   w_best_idx;
    logic [CYW-1:0]  w_best_cyl;
    logic [CYW-1:0]  w_best_d;

    assign o_s_axis_tready = (r_state == ssf_pkg::ST_IDLE);
    assign w_s_acc = i_s_axis_tvalid && o_s_axis_tready;
    assign w_op    = ssf_pkg::t_op'(i_s_axis_tuser[0]);
    assign w_load  = w_s_acc && (w_op == ssf_pkg::OP_LOAD);
    assign w_run   = w_s_acc && (w_op == ssf_pkg::OP_RUN);
    assign w_full  = (r_count == CW'(DEPTH));
    assign w_fire  = (r_state == ssf_pkg::ST_EMIT) && (!r_m_valid || i_m_axis_tready);

    assign w_issue_last  = (CW'(r_idx) == (r_n - CW'(1)));
    assign w_served_last = (r_served == (r_n - CW'(1)));

    // Saturating running distance
    assign w_sum_ext  = {1'b0, r_sum} + (DW + 1)'(w_best_d);
    assign w_sum_next = (w_sum_ext > {1'b0, ssf_pkg::DIST_MAX}) ? ssf_pkg::DIST_MAX
                                                                 : w_sum_ext[DW-1:0];

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ssf_pkg::ST_IDLE: begin
                if (w_run) begin
                    n_state = (r_count == '0) ? ssf_pkg::ST_EMIT : ssf_pkg::ST_SCAN;
                end
            end
            ssf_pkg::ST_SCAN: begin
                if (w_issue_last) begin
                    n_state = ssf_pkg::ST_WAIT;
                end
            end
            ssf_pkg::ST_WAIT: begin
                n_state = ssf_pkg::ST_EMIT;
            end
            ssf_pkg::ST_EMIT: begin
                if (w_fire) begin
                    n_state = (r_empty || w_served_last) ? ssf_pkg::ST_IDLE
                                                         : ssf_pkg::ST_SCAN;
                end
            end
            default: n_state = ssf_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ssf_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_ovf     <= 1'b0;
            r_idx     <= '0;
            r_served  <= '0;
            r_empty   <= 1'b0;
            r_rd_vld  <= 1'b0;
            r_m_valid <= 1'b0;
        end else begin
            r_rd_vld <= (r_state == ssf_pkg::ST_SCAN);
            if (w_load) begin
                if (w_full) begin
                    r_ovf <= 1'b1;
                end else begin
                    r_count <= r_count + CW'(1);
                end
            end
            if (w_run) begin
                r_count  <= '0;
                r_ovf    <= 1'b0;
                r_idx    <= '0;
                r_served <= '0;
                r_empty  <= (r_count == '0);
            end
            if (r_state == ssf_pkg::ST_SCAN) begin
                r_idx <= w_issue_last ? '0 : r_idx + IW'(1);
            end
            if (w_fire) begin
                r_served  <= r_served + CW'(1);
                r_m_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    // Run context
    always_ff @(posedge i_clk) begin
        r_rd_idx <= r_idx;
        if (w_run) begin
            r_n       <= r_count;
            r_run_ovf <= r_ovf;
            r_head    <= i_s_axis_tdata[CYW-1:0];
            r_sum     <= '0;
        end else if (w_fire) begin
            r_head <= w_best_cyl;
            r_sum  <= w_sum_next;
        end
    end

    // Memory write: new request on load, retire served entry on emit
    always_comb begin
        w_we = 1'b0;
        w_wa = r_count[IW-1:0];
        w_wd = {1'b1, i_s_axis_tdata[CYW-1:0]};
        if (w_load && !w_full) begin
            w_we = 1'b1;
        end else if (w_fire && !r_empty) begin
            w_we = 1'b1;
            w_wa = w_best_idx;
            w_wd = {1'b0, w_best_cyl};
        end
    end

    // Buffer memory, one write and one registered read port
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_wa] <= w_wd;
        end
        r_rd_word <= r_mem[r_idx];
    end

    // Nearest-entry tracker
    assign w_ctl.clear = (r_state == ssf_pkg::ST_SCAN) && (r_idx == '0);
    assign w_ctl.vld   = r_rd_vld;

    ssf_nearest #(
        .IW (IW)
    ) u_nearest (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (w_ctl),
        .i_rd_idx   (r_rd_idx),
        .i_rd_pend  (r_rd_word[CYW]),
        .i_rd_cyl   (r_rd_word[CYW-1:0]),
        .i_head     (r_head),
        .o_found    (w_found),
        .o_best_idx (w_best_idx),
        .o_best_cyl (w_best_cyl),
        .o_best_d   (w_best_d)
    );

    // Output register
    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_m_cyl   <= r_empty ? r_head : w_best_cyl;
            r_m_dist  <= r_empty ? '0 : w_sum_next;
            r_m_last  <= r_empty || w_served_last;
            r_m_empty <= r_empty;
            r_m_ovf   <= r_run_ovf;
        end
    end

    assign o_m_axis_tvalid = r_m_valid;
    assign o_m_axis_tdata  = {(ssf_pkg::M_DATA_W - DW - CYW)'(0), r_m_dist, r_m_cyl};
    assign o_m_axis_tlast  = r_m_last;
    assign o_m_axis_tuser  = {r_m_ovf, r_m_empty};

    // Checks
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("request count exceeds buffer depth");

    a_found_at_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ssf_pkg::ST_EMIT && !r_empty) |-> w_found)
        else $error("emit without a pending request found");

    a_run_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_run |=> (r_count == '0 && !r_ovf))
        else $error("run did not clear buffer count and overflow");

endmodule

### sim/tb_shortest_seek_first_scheduler.sv
// ============================================================================
// tb_shortest_seek_first_scheduler
// Self-checking bench for the nearest-first request scheduler. Request
// cylinders are loaded and runs are started over the input stream. A
// scoreboard keeps its own copy of the request buffer and predicts the service
// order, the running seek totals and the flags of every result word. Those
// predictions are compared with the output stream while both sides idle and
// stall at random.
// ============================================================================
module tb_shortest_seek_first_scheduler;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int BUF_DEPTH  = ssf_pkg::DEPTH_DEF;
    localparam int ITEMS      = 260;
    localparam int HOLD_LEN   = 600;
    localparam int TAIL_LEN   = 200;
    localparam int CYCLE_CAP  = 4000000;

    // One result word as the block should present it
    typedef struct packed {
        logic [ssf_pkg::CYL_W-1:0]  cyl;
        logic [ssf_pkg::DIST_W-1:0] seek_sum;
        logic                       last;
        logic                       empty;
        logic                       ovf;
    } t_seek_res;

    // ------------------------------------------------------------------------
    // Scoreboard: mirror of the request buffer plus the queue of due results
    // ------------------------------------------------------------------------
    class seek_scoreboard;
        logic [ssf_pkg::CYL_W-1:0] req_cyl[$];
        bit                        ovf_flag;
        t_seek_res                 due_q[$];
        int                        errors;

        // Update the buffer mirror; a run expands into its service order
        function void note_word(ssf_pkg::t_op op, logic [ssf_pkg::CYL_W-1:0] cyl);
            bit          taken [BUF_DEPTH];
            int unsigned head, total, best_d, d;
            int          best, n;
            bit          found;
            t_seek_res   res;
            if (op == ssf_pkg::OP_LOAD) begin
                if (req_cyl.size() < BUF_DEPTH) req_cyl.push_back(cyl);
                else ovf_flag = 1'b1;
                return;
            end
            n = req_cyl.size();
            if (n == 0) begin
                res = '{cyl: cyl, seek_sum: '0, last: 1'b1, empty: 1'b1, ovf: ovf_flag};
                due_q.push_back(res);
            end
            foreach (taken[i]) taken[i] = 1'b0;
            head  = cyl;
            total = 0;
            for (int k = 0; k < n; k++) begin
                found  = 1'b0;
                best   = 0;
                best_d = 0;
                // strict compare keeps the lowest index on a tie
                for (int i = 0; i < n; i++) begin
                    if (taken[i]) continue;
                    d = (head > req_cyl[i]) ? head - req_cyl[i] : req_cyl[i] - head;
                    if (!found || d < best_d) begin
                        found  = 1'b1;
                        best   = i;
                        best_d = d;
                    end
                end
                taken[best] = 1'b1;
                total = total + best_d;
                if (total > ssf_pkg::DIST_MAX) total = ssf_pkg::DIST_MAX;
                head = req_cyl[best];
                res = '{cyl: req_cyl[best], seek_sum: total[ssf_pkg::DIST_W-1:0],
                        last: (k == n - 1), empty: 1'b0, ovf: ovf_flag};
                due_q.push_back(res);
            end
            req_cyl.delete();
            ovf_flag = 1'b0;
        endfunction

        // Compare one received word with the oldest prediction
        function void check_result(t_seek_res got);
            t_seek_res want;
            if (due_q.size() == 0) begin
                $display("%0t: unexpected result cyl=%0d sum=%0d last=%0b empty=%0b ovf=%0b",
                         $time, got.cyl, got.seek_sum, got.last, got.empty, got.ovf);
                errors++;
                return;
            end
            want = due_q.pop_front();
            if (got.cyl !== want.cyl) begin
                $display("%0t: served_cylinder expected %0d actual %0d",
                         $time, want.cyl, got.cyl);
                errors++;
            end
            if (got.seek_sum !== want.seek_sum) begin
                $display("%0t: total_distance expected %0d actual %0d",
                         $time, want.seek_sum, got.seek_sum);
                errors++;
            end
            if (got.last !== want.last) begin
                $display("%0t: last expected %0b actual %0b", $time, want.last, got.last);
                errors++;
            end
            if (got.empty !== want.empty) begin
                $display("%0t: empty_res expected %0b actual %0b",
                         $time, want.empty, got.empty);
                errors++;
            end
            if (got.ovf !== want.ovf) begin
                $display("%0t: overflowed expected %0b actual %0b", $time, want.ovf, got.ovf);
                errors++;
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset and block ports
    // ------------------------------------------------------------------------
    logic                         i_clk    = 1'b0;
    logic                         rst_n    = 1'b0;
    logic                         s_tvalid = 1'b0;
    logic [ssf_pkg::S_DATA_W-1:0] s_tdata  = '0;   // [15:0] cylinder
    logic [ssf_pkg::S_USER_W-1:0] s_tuser  = '0;   // [0] op
    logic                         m_tready = 1'b0;
    logic                         o_s_axis_tready;
    logic                         o_m_axis_tvalid;
    logic [ssf_pkg::M_DATA_W-1:0] o_m_axis_tdata;  // [15:0] served_cylinder,
                                                   // [37:16] total_distance
    logic                         o_m_axis_tlast;
    logic [ssf_pkg::M_USER_W-1:0] o_m_axis_tuser;  // [0] empty_res, [1] overflowed

    seek_scoreboard board;
    int             words_sent  = 0;
    int             burst_left  = 0;
    int             cycle_count = 0;
    bit             hold_request = 1'b0;
    bit             hold_active  = 1'b0;

    always #1 i_clk = ~i_clk;

    shortest_seek_first_scheduler #(
        .DEPTH(BUF_DEPTH)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    // Run watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_CAP) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Output monitor: every accepted word goes to the scoreboard
    always @(posedge i_clk) begin
        if (rst_n && o_m_axis_tvalid && m_tready)
            board.check_result('{cyl: o_m_axis_tdata[15:0], seek_sum: o_m_axis_tdata[37:16],
                                 last: o_m_axis_tlast, empty: o_m_axis_tuser[0],
                                 ovf: o_m_axis_tuser[1]});
    end

    // Receiver: segments of steady, random, sparse or toggling ready, plus one
    // long hold-off on request
    initial begin
        int unsigned seg_len, mode;
        forever begin
            if (hold_request) begin
                hold_request = 1'b0;
                hold_active  = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_LEN) @(posedge i_clk);
                hold_active = 1'b0;
            end
            seg_len = $urandom_range(10, 150);
            mode    = $urandom_range(0, 3);
            repeat (seg_len) begin
                case (mode)
                    0: m_tready <= 1'b1;
                    1: m_tready <= 1'($urandom_range(0, 1));
                    2: m_tready <= ($urandom_range(0, 3) == 0);
                    default: m_tready <= ~m_tready;
                endcase
                @(posedge i_clk);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Sender
    // ------------------------------------------------------------------------

    // Offer one word, wait for the handshake, then maybe start a gap
    task automatic offer(input ssf_pkg::t_op op, input logic [ssf_pkg::CYL_W-1:0] cyl);
        s_tvalid <= 1'b1;
        s_tdata  <= cyl;
        s_tuser  <= op;
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        board.note_word(op, cyl);
        words_sent++;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            s_tvalid <= 1'b0;
            s_tdata  <= ssf_pkg::S_DATA_W'($urandom);
            s_tuser  <= ssf_pkg::S_USER_W'($urandom);
            repeat ($urandom_range(1, 10)) @(posedge i_clk);
            burst_left = $urandom_range(0, 24);
        end
    endtask

    // Stop offering until every predicted result has been received
    task automatic wait_drain();
        s_tvalid <= 1'b0;
        while (board.due_q.size() != 0) @(posedge i_clk);
    endtask

    // Cylinder near an anchor (ties and duplicates), anywhere, or at an extreme
    function automatic logic [ssf_pkg::CYL_W-1:0] pick_cyl(
        input logic [ssf_pkg::CYL_W-1:0] anchor,
        input int unsigned style);
        case (style)
            0: return ssf_pkg::CYL_W'($urandom_range(0, 65535));
            1: return anchor + ssf_pkg::CYL_W'($urandom_range(0, 16)) - ssf_pkg::CYL_W'(8);
            default: return $urandom_range(0, 1) ? {ssf_pkg::CYL_W{1'b1}}
                                                 : {ssf_pkg::CYL_W{1'b0}};
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        logic [ssf_pkg::CYL_W-1:0] anchor;
        int unsigned               style, kind, n;
        bit                        drained;
        drained = 1'b0;
        board = new();
        repeat (6) @(posedge i_clk);
        rst_n <= 1'b1;

        // Directed: empty run, ties on distance, duplicates, extremes
        offer(ssf_pkg::OP_RUN, 16'd0);
        offer(ssf_pkg::OP_LOAD, 16'd100);
        offer(ssf_pkg::OP_LOAD, 16'd300);
        offer(ssf_pkg::OP_LOAD, 16'hFFFF);
        offer(ssf_pkg::OP_LOAD, 16'd0);
        offer(ssf_pkg::OP_LOAD, 16'hFFFF);
        offer(ssf_pkg::OP_RUN, 16'd200);
        offer(ssf_pkg::OP_RUN, 16'hFFFF);
        offer(ssf_pkg::OP_LOAD, 16'd5);
        offer(ssf_pkg::OP_RUN, 16'd5);
        offer(ssf_pkg::OP_LOAD, 16'hAAAA);
        offer(ssf_pkg::OP_LOAD, 16'h5555);
        offer(ssf_pkg::OP_RUN, 16'h8000);
        wait_drain();

        // Long receiver hold-off while the sender keeps pushing back to back
        hold_request = 1'b1;
        wait (hold_active);
        burst_left = 20;
        repeat (4) offer(ssf_pkg::OP_LOAD, ssf_pkg::CYL_W'($urandom));
        offer(ssf_pkg::OP_RUN, ssf_pkg::CYL_W'($urandom));
        repeat (3) offer(ssf_pkg::OP_LOAD, ssf_pkg::CYL_W'($urandom));
        offer(ssf_pkg::OP_RUN, ssf_pkg::CYL_W'($urandom));

        // Overfilled buffer: loads past the depth are dropped and flagged
        anchor = ssf_pkg::CYL_W'($urandom);
        repeat (BUF_DEPTH + 2) offer(ssf_pkg::OP_LOAD, pick_cyl(anchor, 1));
        offer(ssf_pkg::OP_RUN, anchor);
        offer(ssf_pkg::OP_RUN, anchor);

        // Random: mostly load bursts closed by a run, some stray words
        while (words_sent < ITEMS) begin
            kind   = $urandom_range(0, 19);
            anchor = ssf_pkg::CYL_W'($urandom);
            style  = $urandom_range(0, 2);
            if (kind < 3) begin
                offer(ssf_pkg::t_op'($urandom_range(0, 1)), pick_cyl(anchor, 0));
            end else begin
                n = (kind == 3) ? $urandom_range(BUF_DEPTH - 4, BUF_DEPTH + 4)
                                : $urandom_range(0, 9);
                repeat (n) offer(ssf_pkg::OP_LOAD, pick_cyl(anchor, style));
                offer(ssf_pkg::OP_RUN, pick_cyl(anchor, style));
            end
            if (!drained && words_sent >= ITEMS / 2) begin
                wait_drain();
                drained = 1'b1;
            end
        end
        // close any open load burst so every word is flushed out
        offer(ssf_pkg::OP_RUN, ssf_pkg::CYL_W'($urandom));

        wait_drain();
        repeat (TAIL_LEN) @(posedge i_clk);
        if (board.errors == 0 && board.due_q.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
